// ===== hdl/oewm_pkg.sv =====
package oewm_pkg;

	// word store capacity in letters
	localparam int unsigned MAX_LETTERS = 32;
	localparam int unsigned LETTER_W    = 8;
	localparam int unsigned OPCODE_W    = 2;
	// length counters must hold MAX_LETTERS itself
	localparam int unsigned LEN_W       = $clog2(MAX_LETTERS + 1);
	localparam int unsigned IDX_W       = $clog2(MAX_LETTERS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// opcodes on the input channel
	localparam logic [OPCODE_W-1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_EVALUATE      = 2'd2;

	typedef enum logic [1:0] {
		KIND_APPEND_FIRST,
		KIND_APPEND_SECOND,
		KIND_EVAL
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [LETTER_W-1:0]  letter;
	} cmd_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic  valid;
		cmd_t  cmd;
	} q_head_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_SAME,
		MODE_FIRST_LONG,
		MODE_SECOND_LONG
	} mode_t;

endpackage

// ===== hdl/oewm_in_if.sv =====
interface oewm_in_if;
	logic                                valid;
	logic                                ready;
	logic [oewm_pkg::OPCODE_W-1:0]       opcode;
	logic [oewm_pkg::LETTER_W-1:0]       letter;

	modport source (output valid, output opcode, output letter, input ready);
	modport sink (input valid, input opcode, input letter, output ready);
endinterface

// ===== hdl/oewm_out_if.sv =====
interface oewm_out_if;
	logic valid;
	logic ready;
	logic related;
	logic overflow;

	modport source (output valid, output related, output overflow, input ready);
	modport sink (input valid, input related, input overflow, output ready);
endinterface

// ===== hdl/oewm_ram.sv =====
module oewm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/oewm_front.sv =====
module oewm_front (
	input  logic              clk,
	input  logic              arst_n,
	oewm_in_if.sink           item,
	input  logic              pop,
	output oewm_pkg::q_head_t head
);

	logic                          accept;
	logic                          push;
	oewm_pkg::cmd_t                cmd;
	oewm_pkg::cmd_t                q_mem_q [oewm_pkg::QUEUE_DEPTH];
	logic [oewm_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [oewm_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [oewm_pkg::QCNT_W-1:0]   count_q;
	logic                          do_pop;

	assign item.ready = (count_q != oewm_pkg::QCNT_W'(oewm_pkg::QUEUE_DEPTH));
	assign accept     = item.valid && item.ready;

	// classify the beat; the unused opcode is accepted and dropped
	always_comb begin
		cmd.letter = item.letter;
		cmd.kind   = oewm_pkg::KIND_EVAL;
		push       = 1'b0;
		unique case (item.opcode)
			oewm_pkg::OP_APPEND_FIRST: begin
				cmd.kind = oewm_pkg::KIND_APPEND_FIRST;
				push     = accept;
			end
			oewm_pkg::OP_APPEND_SECOND: begin
				cmd.kind = oewm_pkg::KIND_APPEND_SECOND;
				push     = accept;
			end
			oewm_pkg::OP_EVALUATE: begin
				cmd.kind = oewm_pkg::KIND_EVAL;
				push     = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = q_mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/oewm_back.sv =====
module oewm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  oewm_pkg::q_head_t head,
	output logic              pop,
	oewm_out_if.source        result
);

	localparam int unsigned LW = oewm_pkg::LEN_W;
	localparam int unsigned IW = oewm_pkg::IDX_W;

	oewm_pkg::state_t             state_q;
	oewm_pkg::state_t             state_d;
	oewm_pkg::mode_t              mode_q;
	oewm_pkg::mode_t              eval_mode;

	logic [LW-1:0]                len_a_q;
	logic [LW-1:0]                len_b_q;
	logic                         ovf_q;
	logic [LW-1:0]                k_q;
	logic [LW-1:0]                n_q;
	logic                         shifted_q;
	logic                         mism_q;
	logic                         rel_q;
	logic                         res_ovf_q;
	logic                         out_valid_q;
	logic                         out_related_q;
	logic                         out_overflow_q;

	logic                         is_eval;
	logic                         is_app_a;
	logic                         is_app_b;
	logic                         a_full;
	logic                         b_full;
	logic                         we_a;
	logic                         we_b;
	logic                         re;
	logic [IW-1:0]                raddr_a;
	logic [IW-1:0]                raddr_b;
	logic [oewm_pkg::LETTER_W-1:0] rdata_a;
	logic [oewm_pkg::LETTER_W-1:0] rdata_b;

	logic                         same_len;
	logic                         a_long;
	logic                         b_long;
	logic [LW-1:0]                eval_n;
	logic                         eval_walk;
	logic                         eval_rel;

	logic                         eq;
	logic                         last;
	logic                         fail;
	logic                         redo;
	logic                         finish;
	logic                         load;

	// letter stores
	oewm_ram #(.WIDTH(oewm_pkg::LETTER_W), .DEPTH(oewm_pkg::MAX_LETTERS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (len_a_q[IW-1:0]),
		.wdata (head.cmd.letter),
		.re    (re),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	oewm_ram #(.WIDTH(oewm_pkg::LETTER_W), .DEPTH(oewm_pkg::MAX_LETTERS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (len_b_q[IW-1:0]),
		.wdata (head.cmd.letter),
		.re    (re),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// command decode
	assign is_eval  = (head.cmd.kind == oewm_pkg::KIND_EVAL);
	assign is_app_a = (head.cmd.kind == oewm_pkg::KIND_APPEND_FIRST);
	assign is_app_b = (head.cmd.kind == oewm_pkg::KIND_APPEND_SECOND);
	assign a_full   = (len_a_q == LW'(oewm_pkg::MAX_LETTERS));
	assign b_full   = (len_b_q == LW'(oewm_pkg::MAX_LETTERS));

	// length relation at evaluate
	assign same_len = (len_a_q == len_b_q);
	assign a_long   = ({1'b0, len_a_q} == ({1'b0, len_b_q} + (LW+1)'(1)));
	assign b_long   = ({1'b0, len_b_q} == ({1'b0, len_a_q} + (LW+1)'(1)));

	always_comb begin
		eval_mode = oewm_pkg::MODE_SAME;
		eval_n    = len_a_q;
		eval_walk = 1'b0;
		eval_rel  = 1'b0;
		priority if (ovf_q) begin
			eval_rel = 1'b0;
		end else if (same_len) begin
			eval_mode = oewm_pkg::MODE_SAME;
			eval_n    = len_a_q;
			eval_walk = (len_a_q != '0);
			eval_rel  = 1'b1;
		end else if (a_long) begin
			eval_mode = oewm_pkg::MODE_FIRST_LONG;
			eval_n    = len_b_q;
			eval_walk = (len_b_q != '0);
			eval_rel  = 1'b1;
		end else if (b_long) begin
			eval_mode = oewm_pkg::MODE_SECOND_LONG;
			eval_n    = len_a_q;
			eval_walk = (len_a_q != '0);
			eval_rel  = 1'b1;
		end else begin
			eval_rel = 1'b0;
		end
	end

	// read addresses: the longer word runs one ahead once a skip is taken
	assign raddr_a = (mode_q == oewm_pkg::MODE_FIRST_LONG) ?
		IW'(k_q + LW'(shifted_q)) : k_q[IW-1:0];
	assign raddr_b = (mode_q == oewm_pkg::MODE_SECOND_LONG) ?
		IW'(k_q + LW'(shifted_q)) : k_q[IW-1:0];

	// compare step
	assign eq     = (rdata_a == rdata_b);
	assign last   = (({1'b0, k_q} + (LW+1)'(1)) == {1'b0, n_q});
	assign fail   = !eq && ((mode_q == oewm_pkg::MODE_SAME) ? mism_q : shifted_q);
	assign redo   = !eq && !shifted_q && (mode_q != oewm_pkg::MODE_SAME);
	assign finish = fail || (last && !redo);

	assign load = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oewm_pkg::ST_IDLE: begin
				if (head.valid && is_eval) begin
					state_d = eval_walk ? oewm_pkg::ST_READ : oewm_pkg::ST_DONE;
				end
			end
			oewm_pkg::ST_READ: begin
				state_d = oewm_pkg::ST_CMP;
			end
			oewm_pkg::ST_CMP: begin
				state_d = finish ? oewm_pkg::ST_DONE : oewm_pkg::ST_READ;
			end
			oewm_pkg::ST_DONE: begin
				if (load) begin
					state_d = oewm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oewm_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop  = (state_q == oewm_pkg::ST_IDLE) && head.valid;
		we_a = pop && is_app_a && !a_full;
		we_b = pop && is_app_b && !b_full;
		re   = (state_q == oewm_pkg::ST_READ);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oewm_pkg::ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				if (is_eval) begin
					len_a_q <= '0;
					len_b_q <= '0;
					ovf_q   <= 1'b0;
				end else if (is_app_a) begin
					if (a_full) begin
						ovf_q <= 1'b1;
					end else begin
						len_a_q <= len_a_q + 1'b1;
					end
				end else if (is_app_b) begin
					if (b_full) begin
						ovf_q <= 1'b1;
					end else begin
						len_b_q <= len_b_q + 1'b1;
					end
				end
			end
			if (state_q == oewm_pkg::ST_DONE && load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			oewm_pkg::ST_IDLE: begin
				if (pop && is_eval) begin
					mode_q    <= eval_mode;
					n_q       <= eval_n;
					k_q       <= '0;
					shifted_q <= 1'b0;
					mism_q    <= 1'b0;
					rel_q     <= eval_rel;
					res_ovf_q <= ovf_q;
				end
			end
			oewm_pkg::ST_CMP: begin
				rel_q <= !fail;
				if (redo) begin
					shifted_q <= 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
				if (!eq) begin
					mism_q <= 1'b1;
				end
			end
			oewm_pkg::ST_DONE: begin
				if (load) begin
					out_related_q  <= rel_q;
					out_overflow_q <= res_ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid    = out_valid_q;
	assign result.related  = out_related_q;
	assign result.overflow = out_overflow_q;

endmodule

// ===== hdl/one_edit_word_match.sv =====
// Checks whether two words are at most one edit apart. Beats with opcode 0
// and 1 append a letter to the first and second word; a beat with opcode 2
// returns one result (related, overflow) and clears both words; opcode 3 is
// accepted and ignored. Each word holds oewm_pkg::MAX_LETTERS letters;
// further letters are dropped and the next result reports overflow with
// related low. A two-entry command queue separates input acceptance from
// execution. An evaluate walks the words through the registered read ports
// of the two letter stores, each compared position passing through a read
// state and a compare state; a position is compared again when a letter of
// the longer word is skipped, the walk stops early on a mismatch, and no
// walk is done when none is needed (overflow, an empty shorter word, or
// lengths two or more apart); a result then waits in an output register
// while later appends proceed.
module one_edit_word_match (
	input  logic        clk,
	input  logic        arst_n,
	oewm_in_if.sink     item,
	oewm_out_if.source  result
);

	oewm_pkg::q_head_t head;
	logic              pop;

	oewm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.pop    (pop),
		.head   (head)
	);

	oewm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule
